FILE: src/pwl_pkg.sv
// Shared types, constants and codes for the piecewise linear interpolation table.
package pwl_pkg;

   localparam int DefaultDepth = 256;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [31:0]        key;
      logic signed [31:0] load_real;
      logic signed [31:0] load_imag;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_real;
      logic signed [31:0] result_imag;
      logic [1:0]         status;
   } rsp_type;

   // one table entry as held in memory
   typedef struct packed {
      logic [31:0] key;
      logic [31:0] re;
      logic [31:0] im;
   } point_type;

endpackage

FILE: src/pwl_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module pwl_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/pwl_div.sv
// Shared unsigned restoring divider: 64-bit dividend by 33-bit divisor, one bit a cycle.
module pwl_div
   import pwl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [34:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[32:0], quo_ff[63]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = 7'd64;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[34]) begin
            rem_in = diff[33:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done |-> $past(run_ff))
      else $error("divider done without a run");
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> cnt_ff != 7'd0)
      else $error("divider running with zero count");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider restarted while busy");
endmodule

FILE: src/pwl_ctrl.sv
// Sequencer: table clear, sorted insertion by shifting, clamp checks, binary search and lerp.
module pwl_ctrl
   import pwl_pkg::*;
#(
   parameter int TableDepth = DefaultDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  req_type                       req,
   output logic                          busy,
   output logic                          rsp_valid,
   output rsp_type                       rsp,
   output logic                          wr_en,
   output logic [$clog2(TableDepth)-1:0] wr_addr,
   output point_type                     wr_data,
   output logic [$clog2(TableDepth)-1:0] rd_addr,
   input  point_type                     rd_data,
   output logic                          div_start,
   output logic [63:0]                   div_dividend,
   output logic [32:0]                   div_divisor,
   input  logic                          div_done,
   input  logic [63:0]                   div_quotient
);
   localparam int AW = $clog2(TableDepth);
   localparam int CW = $clog2(TableDepth + 1);
   localparam logic [CW-1:0] Full = CW'(TableDepth);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SHIFT  = 4'd1;  // read entry i-1 (compared in S_SHWAIT)
   localparam logic [3:0] S_SHWAIT = 4'd2;
   localparam logic [3:0] S_FIRST  = 4'd3;
   localparam logic [3:0] S_LAST   = 4'd4;
   localparam logic [3:0] S_SRCH   = 4'd5;
   localparam logic [3:0] S_LO     = 4'd6;
   localparam logic [3:0] S_HI     = 4'd7;
   localparam logic [3:0] S_DIVRE  = 4'd8;
   localparam logic [3:0] S_DIVIM  = 4'd9;
   localparam logic [3:0] S_RESP   = 4'd10;
   localparam logic [3:0] S_WAIT   = 4'd11;

   logic [3:0]    state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in, lo_ff, lo_in, hi_ff, hi_in;
   req_type       req_ff, req_in;
   point_type     p1_ff, p1_in;
   logic [31:0]   den_ff, den_in, num_ff, num_in;
   logic [31:0]   mag_ff, mag_in;
   logic          neg_ff, neg_in;
   logic [63:0]   prod_ff, prod_in;
   logic          mulgo_ff, mulgo_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rspv_ff, rspv_in;
   logic [CW-1:0] mid;
   logic [32:0]   dz;
   logic [31:0]   z1, z2, zq;

   always_comb begin
      mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   end

   // pick component for divider pass and form the signed difference
   always_comb begin
      z1 = (state_ff == S_DIVRE || ret_ff == S_DIVRE) ? p1_ff.re : p1_ff.im;
      z2 = (state_ff == S_DIVRE || ret_ff == S_DIVRE) ? rd_data.re : rd_data.im;
      dz = {z2[31], z2} - {z1[31], z1};
      zq = neg_ff ? z1 - div_quotient[31:0] : z1 + div_quotient[31:0];
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      req_in   = req_ff;
      p1_in    = p1_ff;
      den_in   = den_ff;
      num_in   = num_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      mulgo_in = 1'b0;
      rsp_in   = rsp_ff;
      rspv_in  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = idx_ff[AW-1:0];
      wr_data  = rd_data;
      rd_addr  = '0;
      div_start = mulgo_ff;
      div_dividend = prod_ff;
      div_divisor  = {1'b0, den_ff};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req;
               rsp_in = '0;
               idx_in = count_ff;
               case (req.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  OP_LOAD: begin
                     if (count_ff == Full) begin
                        rsp_in.status = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SHIFT;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        state_in = S_RESP;
                     end else begin
                        rd_addr  = '0;
                        state_in = S_FIRST;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SHIFT: begin
            if (idx_ff == '0) begin
               wr_en   = 1'b1;
               wr_data = '{key: req_ff.key, re: req_ff.load_real, im: req_ff.load_imag};
               count_in = count_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               rd_addr  = AW'(idx_ff - CW'(1));
               state_in = S_SHWAIT;
            end
         end
         S_SHWAIT: begin
            rd_addr = AW'(idx_ff - CW'(1));
            if (rd_data.key <= req_ff.key) begin
               wr_en   = 1'b1;
               wr_data = '{key: req_ff.key, re: req_ff.load_real, im: req_ff.load_imag};
               count_in = count_ff + CW'(1);
               state_in = S_RESP;
            end else begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = idx_ff - CW'(1);
               state_in = S_SHIFT;
            end
         end
         S_FIRST: begin
            rd_addr = AW'(count_ff - CW'(1));
            if (req_ff.key <= rd_data.key) begin
               rsp_in.result_real = rd_data.re;
               rsp_in.result_imag = rd_data.im;
               state_in = S_RESP;
            end else begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (req_ff.key >= rd_data.key) begin
               rsp_in.result_real = rd_data.re;
               rsp_in.result_imag = rd_data.im;
               state_in = S_RESP;
            end else begin
               lo_in = '0;
               hi_in = count_ff;
               rd_addr  = AW'(CW'(0) + ((count_ff) >> 1));
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            // rd_data holds the table entry at mid
            if (lo_ff == hi_ff) begin
               idx_in   = lo_ff - CW'(1);
               rd_addr  = AW'(lo_ff - CW'(1));
               state_in = S_LO;
            end else begin
               if (rd_data.key < req_ff.key) begin
                  lo_in = mid + CW'(1);
                  rd_addr = AW'(mid + CW'(1) + ((hi_ff - mid - CW'(1)) >> 1));
               end else begin
                  hi_in = mid;
                  rd_addr = AW'(lo_ff + ((mid - lo_ff) >> 1));
               end
               if (rd_data.key < req_ff.key && mid + CW'(1) == hi_ff) begin
                  rd_addr = AW'(mid);
               end
            end
         end
         S_LO: begin
            p1_in    = rd_data;
            num_in   = req_ff.key - rd_data.key;
            rd_addr  = AW'(idx_ff + CW'(1));
            state_in = S_HI;
            ret_in   = S_DIVRE;
         end
         S_HI: begin
            rd_addr = AW'(idx_ff + CW'(1));
            den_in  = rd_data.key - p1_ff.key;
            neg_in  = dz[32];
            mag_in  = dz[32] ? 32'(-dz) : dz[31:0];
            state_in = S_WAIT;
         end
         S_WAIT: begin
            // product registered, then the divider takes it
            rd_addr  = AW'(idx_ff + CW'(1));
            prod_in  = 64'(mag_ff) * 64'(num_ff);
            mulgo_in = 1'b1;
            state_in = ret_ff;
         end
         S_DIVRE: begin
            rd_addr = AW'(idx_ff + CW'(1));
            if (div_done) begin
               rsp_in.result_real = zq;
               ret_in   = S_DIVIM;
               state_in = S_HI;
            end
         end
         S_DIVIM: begin
            rd_addr = AW'(idx_ff + CW'(1));
            if (div_done) begin
               rsp_in.result_imag = zq;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            rspv_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      p1_ff   <= p1_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
      ret_ff  <= ret_in;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rspv_ff  <= 1'b0;
         mulgo_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rspv_ff  <= rspv_in;
         mulgo_ff <= mulgo_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp       = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Full)
      else $error("point count beyond table depth");
   a_rsp_after_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_RESP)
      else $error("response outside response state");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH |-> lo_ff <= hi_ff && hi_ff <= count_ff)
      else $error("search window broken");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses for one command");
endmodule

FILE: src/piecewise_linear_table_interp_top.sv
// Top level: point table memory, sequencer and shared divider.
// One command at a time: start is taken when busy is low, and one response beat
// follows on rsp_valid for one cycle, in the first cycle that busy is low again.
// The receiver cannot stall, so that beat must be taken when it appears. A clear,
// a dropped load, an empty query or opcode 3 goes straight to the response. A
// load walks down from the end of the table, reading each larger entry and moving
// it up one place, then writes the new point into the gap. A query at or below
// the first key returns the first point, one at or above the last key the last
// point. Otherwise the binary search costs one memory read per step plus one, and
// each of the two 64-bit divisions is a product set-up, then the restoring divider.
module piecewise_linear_table_interp_top
   import pwl_pkg::*;
#(
   parameter int TABLE_DEPTH = DefaultDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(TABLE_DEPTH);

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   point_type       wr_data, rd_data;
   logic            div_start, div_done;
   logic [63:0]     div_dividend, div_quotient;
   logic [32:0]     div_divisor;

   pwl_ram #(.Width($bits(point_type)), .Depth(TABLE_DEPTH)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   pwl_div u_div (
      .clock, .reset, .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(div_quotient)
   );

   pwl_ctrl #(.TableDepth(TABLE_DEPTH)) u_ctrl (
      .clock, .reset, .start, .req(req_data), .busy, .rsp_valid, .rsp(rsp_data),
      .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data,
      .div_start, .div_dividend, .div_divisor, .div_done, .div_quotient
   );
endmodule
